### hdl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared constants, types and small arithmetic helpers for the RMC parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    // Sentence buffer limit and byte counter width
    localparam int MAX_SENTENCE_LEN = 96;
    localparam int CNT_W            = $clog2(MAX_SENTENCE_LEN + 1);

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    // Expected header, entry 0 is the opening '$'
    localparam int HDR_LEN = 6;
    localparam logic [HDR_LEN-1:0][7:0] HDR_CHARS =
        {CH_C, CH_M, CH_R, CH_P, CH_G, CH_DOLLAR};

    // Field positions
    localparam int TIME_FIRST      = 7;
    localparam int N_DIGITS        = 6;
    localparam int COMMA_SCAN_FROM = 12;
    localparam int DATE_COMMAS     = 8;
    localparam int STATUS_COMMAS   = 2;
    localparam int DATE_DONE       = DATE_COMMAS + N_DIGITS;

    typedef enum logic {
        PH_HUNT,
        PH_COLLECT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OK         = 2'd0,
        KIND_BAD_HEADER = 2'd1,
        KIND_BAD_CSUM   = 2'd2,
        KIND_OVERFLOW   = 2'd3
    } kind_t;

    // Snapshot of the sentence at the byte that closes it
    typedef struct packed {
        logic                      done;
        logic                      overflow;
        logic                      hdr_ok;
        logic [7:0]                csum_calc;
        logic [7:0]                csum_hi_ch;
        logic [7:0]                csum_lo_ch;
        logic [N_DIGITS-1:0][7:0]  time_dig;
        logic [N_DIGITS-1:0][7:0]  date_dig;
        logic [7:0]                status;
        logic                      stray;
    } snap_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] fix_status;
        logic       stray;
    } result_t;

    // Hex character value, no validity check
    function automatic logic [7:0] hex_val(input logic [7:0] ch);
        logic [7:0] d;
        d = ch - CH_ZERO;
        if (d > 8'd9) begin
            d = d - 8'd7;
        end
        return d;
    endfunction

    // (a*10 + b) mod 256 on digit values
    function automatic logic [7:0] pair_val(input logic [7:0] a, input logic [7:0] b);
        return {a[4:0], 3'b000} + {a[6:0], 1'b0} + b;
    endfunction

endpackage

### hdl/nrmc_scan.sv
// ----------------------------------------------------------------------------
// NMEA RMC byte scanner
// Tracks sentence framing per byte: count, running XOR, tail window, header
// match, comma counts and the captured time, date and status fields.
// ----------------------------------------------------------------------------
module nrmc_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output nrmc_pkg::snap_t     snap
);

    nrmc_pkg::phase_t                 phase_reg, phase_next;
    logic [nrmc_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]                       xor_reg, xor_next;
    logic [3:0][7:0]                  win_reg, win_next;
    logic                             hdr_reg, hdr_next;
    logic [1:0]                       cfs_reg, cfs_next;
    logic [3:0]                       cat_reg, cat_next;
    logic [nrmc_pkg::N_DIGITS-1:0][7:0] time_reg, time_next;
    logic [nrmc_pkg::N_DIGITS-1:0][7:0] date_reg, date_next;
    logic [7:0]                       status_reg, status_next;
    logic                             stray_reg, stray_next;

    logic       collecting;
    logic       full;
    logic       is_dollar;
    logic       end_hit;
    logic       ovf_hit;
    logic [7:0] digit;

    // Per-byte events
    assign collecting = (phase_reg == nrmc_pkg::PH_COLLECT);
    assign full       = (cnt_reg >= nrmc_pkg::CNT_W'(nrmc_pkg::MAX_SENTENCE_LEN));
    assign is_dollar  = (rx_byte == nrmc_pkg::CH_DOLLAR);
    assign digit      = rx_byte - nrmc_pkg::CH_ZERO;
    assign ovf_hit    = take && collecting && full;
    assign end_hit    = take && collecting && !full && (rx_byte == nrmc_pkg::CH_LF)
                        && (win_reg[0] == nrmc_pkg::CH_CR);

    // Phase next state
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            nrmc_pkg::PH_HUNT: begin
                if (take && is_dollar) begin
                    phase_next = nrmc_pkg::PH_COLLECT;
                end
            end
            nrmc_pkg::PH_COLLECT: begin
                if (ovf_hit || end_hit) begin
                    phase_next = nrmc_pkg::PH_HUNT;
                end
            end
            default: phase_next = nrmc_pkg::PH_HUNT;
        endcase
    end

    // Sentence tracking datapath
    always_comb begin
        cnt_next    = cnt_reg;
        xor_next    = xor_reg;
        win_next    = win_reg;
        hdr_next    = hdr_reg;
        cfs_next    = cfs_reg;
        cat_next    = cat_reg;
        time_next   = time_reg;
        date_next   = date_reg;
        status_next = status_reg;
        stray_next  = stray_reg;
        if (take) begin
            if (!collecting) begin
                if (is_dollar) begin
                    cnt_next    = nrmc_pkg::CNT_W'(1);
                    xor_next    = '0;
                    win_next    = {24'h0, rx_byte};
                    hdr_next    = 1'b1;
                    cfs_next    = '0;
                    cat_next    = '0;
                    time_next   = '0;
                    date_next   = '0;
                    status_next = '0;
                    stray_next  = 1'b0;
                end
            end else if (full) begin
                cnt_next   = '0;
                stray_next = stray_reg | is_dollar;
            end else begin
                cnt_next   = end_hit ? '0 : cnt_reg + nrmc_pkg::CNT_W'(1);
                xor_next   = xor_reg ^ rx_byte;
                win_next   = {win_reg[2:0], rx_byte};
                stray_next = stray_reg | is_dollar;
                // header match on bytes 1 to 5
                for (int k = 1; k < nrmc_pkg::HDR_LEN; k++) begin
                    if (cnt_reg == nrmc_pkg::CNT_W'(k) && rx_byte != nrmc_pkg::HDR_CHARS[k]) begin
                        hdr_next = 1'b0;
                    end
                end
                // status: byte after the second comma
                if (cfs_reg == 2'(nrmc_pkg::STATUS_COMMAS)) begin
                    status_next = rx_byte;
                    cfs_next    = 2'd3;
                end else if (cfs_reg < 2'(nrmc_pkg::STATUS_COMMAS)
                             && rx_byte == nrmc_pkg::CH_COMMA) begin
                    cfs_next = cfs_reg + 2'd1;
                end
                // time digits at fixed positions
                for (int k = 0; k < nrmc_pkg::N_DIGITS; k++) begin
                    if (cnt_reg == nrmc_pkg::CNT_W'(nrmc_pkg::TIME_FIRST + k)) begin
                        time_next[k] = digit;
                    end
                end
                // date: count commas from the end of time, then take six digits
                if (cat_reg < 4'(nrmc_pkg::DATE_COMMAS)) begin
                    if (cnt_reg >= nrmc_pkg::CNT_W'(nrmc_pkg::COMMA_SCAN_FROM)
                        && rx_byte == nrmc_pkg::CH_COMMA) begin
                        cat_next = cat_reg + 4'd1;
                    end
                end else if (cat_reg < 4'(nrmc_pkg::DATE_DONE)) begin
                    for (int k = 0; k < nrmc_pkg::N_DIGITS; k++) begin
                        if (cat_reg == 4'(nrmc_pkg::DATE_COMMAS + k)) begin
                            date_next[k] = digit;
                        end
                    end
                    cat_next = cat_reg + 4'd1;
                end
            end
        end
    end

    // Snapshot towards the evaluator
    always_comb begin
        snap.done       = end_hit;
        snap.overflow   = ovf_hit;
        snap.hdr_ok     = hdr_next && (cnt_reg >= nrmc_pkg::CNT_W'(nrmc_pkg::HDR_LEN - 1));
        snap.csum_calc  = xor_reg ^ win_reg[0] ^ win_reg[1] ^ win_reg[2] ^ win_reg[3];
        snap.csum_hi_ch = win_reg[2];
        snap.csum_lo_ch = win_reg[1];
        snap.time_dig   = time_next;
        snap.date_dig   = date_next;
        snap.status     = status_next;
        snap.stray      = stray_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= nrmc_pkg::PH_HUNT;
            cnt_reg   <= '0;
            stray_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            stray_reg <= stray_next;
        end
    end

    // Sentence payload registers, set up at each '$'
    always_ff @(posedge aclk) begin
        xor_reg    <= xor_next;
        win_reg    <= win_next;
        hdr_reg    <= hdr_next;
        cfs_reg    <= cfs_next;
        cat_reg    <= cat_next;
        time_reg   <= time_next;
        date_reg   <= date_next;
        status_reg <= status_next;
    end

endmodule

### hdl/nrmc_eval.sv
// ----------------------------------------------------------------------------
// NMEA RMC sentence evaluator
// Checks overflow, header and checksum of a closed sentence and converts the fields.
// ----------------------------------------------------------------------------
module nrmc_eval (
    input  nrmc_pkg::snap_t   snap,
    output nrmc_pkg::result_t res
);

    logic [7:0] hi_val;
    logic [7:0] lo_val;
    logic [7:0] want;

    // Checksum from the two characters before CR LF
    assign hi_val = nrmc_pkg::hex_val(snap.csum_hi_ch);
    assign lo_val = nrmc_pkg::hex_val(snap.csum_lo_ch);
    assign want   = {hi_val[3:0], 4'h0} | lo_val;

    // Result selection
    always_comb begin
        res            = '0;
        res.stray      = snap.stray;
        if (snap.overflow) begin
            res.kind = nrmc_pkg::KIND_OVERFLOW;
        end else if (!snap.hdr_ok) begin
            res.kind = nrmc_pkg::KIND_BAD_HEADER;
        end else if (snap.csum_calc != want) begin
            res.kind = nrmc_pkg::KIND_BAD_CSUM;
        end else begin
            res.kind       = nrmc_pkg::KIND_OK;
            res.hour       = nrmc_pkg::pair_val(snap.time_dig[0], snap.time_dig[1]);
            res.minute     = nrmc_pkg::pair_val(snap.time_dig[2], snap.time_dig[3]);
            res.second     = nrmc_pkg::pair_val(snap.time_dig[4], snap.time_dig[5]);
            res.day        = nrmc_pkg::pair_val(snap.date_dig[0], snap.date_dig[1]);
            res.month      = nrmc_pkg::pair_val(snap.date_dig[2], snap.date_dig[3]);
            res.year       = nrmc_pkg::pair_val(snap.date_dig[4], snap.date_dig[5]);
            res.fix_status = snap.status;
        end
    end

endmodule

### hdl/nmea_rmc_sentence_parser.sv
// A result appears on m_valid in the cycle after the transaction carrying the
// closing LF, or the byte finding the buffer full. Throughput: one byte per
// cycle unless a result waits on m_ready; the byte scanner updates all sentence
// state in a single pass; the result register frees itself when m_ready is high.
// Reset (aresetn low, synchronous): hunting for '$', no result pending.
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser
// Streams UART characters, frames $GPRMC sentences and reports time, date,
// fix status and a result kind per sentence end or buffer overflow.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_hour,
    output logic [7:0] m_minute,
    output logic [7:0] m_second,
    output logic [7:0] m_day,
    output logic [7:0] m_month,
    output logic [7:0] m_year,
    output logic [7:0] m_fix_status,
    output logic       m_stray_start
);

    nrmc_pkg::snap_t   snap;
    nrmc_pkg::result_t res;
    nrmc_pkg::result_t res_reg;
    logic              m_valid_reg, m_valid_next;
    logic              take;
    logic              emit;

    // Input transaction accepted when the result slot is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign emit    = snap.done || snap.overflow;

    nrmc_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .rx_byte (s_rx_byte),
        .snap    (snap)
    );

    nrmc_eval u_eval (
        .snap (snap),
        .res  (res)
    );

    // Result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg <= res;
        end
    end

    // Output ports
    assign m_valid       = m_valid_reg;
    assign m_result_kind = res_reg.kind;
    assign m_hour        = res_reg.hour;
    assign m_minute      = res_reg.minute;
    assign m_second      = res_reg.second;
    assign m_day         = res_reg.day;
    assign m_month       = res_reg.month;
    assign m_year        = res_reg.year;
    assign m_fix_status  = res_reg.fix_status;
    assign m_stray_start = res_reg.stray;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser testbench
// Streams UART characters into the parser: first a table of directed
// sentences, then mostly well-formed RMC sentences with random content,
// mixed with damaged ones, overruns and line noise. The sender runs in
// bursts with gaps and the receiver stalls on its own pattern, including
// one long hold-off that backs the parser up. Every result is checked against a
// cycle-free model of the sentence buffer kept in this file or a directed table entry.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int RAND_BYTES   = 630;
    localparam int RAND_FRAMES  = 8;
    localparam int HOLD_AFTER   = 18;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [7:0] b;
        bit         typed_end;
    } tx_item_t;

    // One row of the directed table
    typedef struct {
        string             head;
        int                pad_n;
        logic [7:0]        pad_ch;
        string             tail;
        bit                seal;
        bit                typed;
        nrmc_pkg::result_t want;
    } dir_row_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       s_tag   = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_result_kind;
    logic [7:0] m_hour, m_minute, m_second, m_day, m_month, m_year, m_fix_status;
    logic       m_stray_start;

    // Stimulus and expectations
    tx_item_t          tx_fifo[$];
    dir_row_t          dir_tbl[$];
    nrmc_pkg::result_t table_results[$];
    nrmc_pkg::result_t parse_results[$];

    // Sentence model state
    logic [7:0]        snt_buf [nrmc_pkg::MAX_SENTENCE_LEN];
    nrmc_pkg::phase_t  snt_phase = nrmc_pkg::PH_HUNT;
    int                snt_len   = 0;
    bit                snt_stray = 1'b0;

    // Bookkeeping
    bit         s_took = 1'b0;
    int         mismatch_count = 0;
    int         results_seen = 0;
    int         bytes_sent = 0;
    int         kind_hits [4];
    int         stray_hits = 0;

    // Sender pacing
    int         burst_left = 0;
    int         gap_left   = 0;

    // Receiver pacing
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         rdy_mode  = 0;
    int         rdy_left  = 0;
    int         rdy_tick  = 0;

    nmea_rmc_sentence_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_hour        (m_hour),
        .m_minute      (m_minute),
        .m_second      (m_second),
        .m_day         (m_day),
        .m_month       (m_month),
        .m_year        (m_year),
        .m_fix_status  (m_fix_status),
        .m_stray_start (m_stray_start)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Sentence model
    // ------------------------------------------------------------------
    function automatic logic [7:0] buf_byte(int idx);
        if (idx >= 0 && idx < snt_len && idx < nrmc_pkg::MAX_SENTENCE_LEN) begin
            return snt_buf[idx];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] buf_digit(int idx);
        if (idx >= 0 && idx < snt_len && idx < nrmc_pkg::MAX_SENTENCE_LEN) begin
            return snt_buf[idx] - nrmc_pkg::CH_ZERO;
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] digit_pair(int idx);
        int v;
        v = int'(buf_digit(idx)) * 10 + int'(buf_digit(idx + 1));
        return v[7:0];
    endfunction

    function automatic logic [7:0] csum_digit(logic [7:0] ch);
        logic [7:0] d;
        d = ch - nrmc_pkg::CH_ZERO;
        if (d > 8'd9) begin
            d = d - 8'd7;
        end
        return d;
    endfunction

    // Position just past the k-th comma from start, or the length if short
    function automatic int skip_commas(int start, int k);
        int i;
        i = start;
        while (k > 0 && i < snt_len) begin
            if (buf_byte(i) == nrmc_pkg::CH_COMMA) begin
                k--;
            end
            i++;
        end
        return (k == 0) ? i : snt_len;
    endfunction

    // Header, checksum and field extraction on a closed sentence
    function automatic nrmc_pkg::result_t judge_sentence();
        nrmc_pkg::result_t r;
        logic [7:0]        cs, hi, lo, want;
        int                n, p;
        r  = '0;
        n  = snt_len;
        cs = 8'h00;
        for (int i = 0; i < nrmc_pkg::HDR_LEN; i++) begin
            if (buf_byte(i) != nrmc_pkg::HDR_CHARS[i]) begin
                r.kind = nrmc_pkg::KIND_BAD_HEADER;
                return r;
            end
        end
        for (int i = 1; i + 5 < n; i++) begin
            cs ^= buf_byte(i);
        end
        hi   = csum_digit(buf_byte(n - 4));
        lo   = csum_digit(buf_byte(n - 3));
        want = {hi[3:0], 4'h0} | lo;
        if (cs != want) begin
            r.kind = nrmc_pkg::KIND_BAD_CSUM;
            return r;
        end
        r.kind   = nrmc_pkg::KIND_OK;
        r.hour   = digit_pair(nrmc_pkg::TIME_FIRST);
        r.minute = digit_pair(nrmc_pkg::TIME_FIRST + 2);
        r.second = digit_pair(nrmc_pkg::TIME_FIRST + 4);
        p = skip_commas(nrmc_pkg::COMMA_SCAN_FROM, nrmc_pkg::DATE_COMMAS);
        if (p < n) begin
            r.day   = digit_pair(p);
            r.month = digit_pair(p + 2);
            r.year  = digit_pair(p + 4);
        end
        p = skip_commas(0, nrmc_pkg::STATUS_COMMAS);
        if (p < n) begin
            r.fix_status = buf_byte(p);
        end
        return r;
    endfunction

    // One received character; returns 1 when it closes a sentence or overflows the buffer
    function automatic bit rmc_step(input logic [7:0] rx, output nrmc_pkg::result_t res);
        res = '0;
        if (snt_phase == nrmc_pkg::PH_HUNT) begin
            if (rx == nrmc_pkg::CH_DOLLAR) begin
                snt_buf[0] = rx;
                snt_len    = 1;
                snt_stray  = 1'b0;
                snt_phase  = nrmc_pkg::PH_COLLECT;
            end
            return 1'b0;
        end
        // buffer full: the byte is dropped
        if (snt_len >= nrmc_pkg::MAX_SENTENCE_LEN) begin
            res.kind  = nrmc_pkg::KIND_OVERFLOW;
            res.stray = snt_stray || (rx == nrmc_pkg::CH_DOLLAR);
            snt_phase = nrmc_pkg::PH_HUNT;
            snt_len   = 0;
            snt_stray = 1'b0;
            return 1'b1;
        end
        if (rx == nrmc_pkg::CH_DOLLAR) begin
            snt_stray = 1'b1;
        end
        snt_buf[snt_len] = rx;
        snt_len++;
        if (rx == nrmc_pkg::CH_LF && snt_len >= 2
            && snt_buf[snt_len - 2] == nrmc_pkg::CH_CR) begin
            res       = judge_sentence();
            res.stray = snt_stray;
            snt_phase = nrmc_pkg::PH_HUNT;
            snt_len   = 0;
            snt_stray = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic nrmc_pkg::result_t mk_res(nrmc_pkg::kind_t k, int hh, int mi, int ss,
                                                 int dd, int mo, int yy, logic [7:0] fix,
                                                 bit stray);
        nrmc_pkg::result_t r;
        r            = '0;
        r.kind       = k;
        r.hour       = hh[7:0];
        r.minute     = mi[7:0];
        r.second     = ss[7:0];
        r.day        = dd[7:0];
        r.month      = mo[7:0];
        r.year       = yy[7:0];
        r.fix_status = fix;
        r.stray      = stray;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
        if (v < 4'd10) begin
            return nrmc_pkg::CH_ZERO + 8'(v);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] rand_digit();
        return nrmc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_text_char();
        string pool = "0123456789.NSEWABC-";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic push_text(ref logic [7:0] q[$], input string s);
        foreach (s[i]) begin
            q.push_back(s[i]);
        end
    endtask

    // Frame the body as "$body*HH<CR><LF>" when sealed, else send it verbatim
    task automatic commit_frame(ref logic [7:0] fr[$], input bit seal, input bit bad_csum,
                                input bit lower, input bit typed);
        logic [7:0] x;
        logic [7:0] out[$];
        x = 8'h00;
        if (seal) begin
            foreach (fr[i]) begin
                x ^= fr[i];
            end
            if (bad_csum) begin
                x ^= 8'($urandom_range(1, 255));
            end
            out.push_back(nrmc_pkg::CH_DOLLAR);
            foreach (fr[i]) begin
                out.push_back(fr[i]);
            end
            out.push_back(8'h2A);
            out.push_back(hex_char(x[7:4], lower));
            out.push_back(hex_char(x[3:0], lower));
            out.push_back(nrmc_pkg::CH_CR);
            out.push_back(nrmc_pkg::CH_LF);
        end else begin
            out = fr;
        end
        foreach (out[i]) begin
            tx_fifo.push_back('{out[i], 1'b0});
        end
        if (out.size() != 0) begin
            tx_fifo[tx_fifo.size() - 1].typed_end = typed;
        end
    endtask

    task automatic dir_row(string head, int pad_n, logic [7:0] pad_ch, string tail,
                           bit seal, bit typed, nrmc_pkg::result_t want);
        dir_tbl.push_back('{head, pad_n, pad_ch, tail, seal, typed, want});
    endtask

    // One random sentence, damaged sentence, overrun or burst of noise
    task automatic gen_random_frame(output bit counted);
        logic [7:0] fr[$];
        int         mode, n_fields, len;
        bit         lower;
        mode    = $urandom_range(0, 99);
        lower   = ($urandom_range(0, 9) == 0);
        counted = 1'b1;
        if (mode < 75) begin
            // RMC body: header, time, status, filler fields, date
            push_text(fr, "GPRMC,");
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 6;
            repeat (len) fr.push_back(rand_digit());
            if ($urandom_range(0, 3) == 0) begin
                fr.push_back(8'h2E);
                repeat ($urandom_range(1, 3)) fr.push_back(rand_digit());
            end
            fr.push_back(nrmc_pkg::CH_COMMA);
            case ($urandom_range(0, 5))
                0, 1, 2: fr.push_back("A");
                3:       fr.push_back("V");
                4:       ;
                default: fr.push_back(8'($urandom_range(0, 255)));
            endcase
            fr.push_back(nrmc_pkg::CH_COMMA);
            n_fields = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 6;
            repeat (n_fields) begin
                repeat ($urandom_range(0, 4)) fr.push_back(rand_text_char());
                fr.push_back(nrmc_pkg::CH_COMMA);
            end
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : 6;
            repeat (len) fr.push_back(rand_digit());
            if ($urandom_range(0, 1) == 1) begin
                push_text(fr, ",,A");
            end
            if ($urandom_range(0, 19) == 0) begin
                fr.insert($urandom_range(0, fr.size() - 1), nrmc_pkg::CH_DOLLAR);
            end
            // damaged header on a slice of them
            if (mode >= 60 && mode < 68) begin
                fr[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
            end
            commit_frame(fr, 1'b1, mode >= 68, lower, 1'b0);
        end else if (mode < 83) begin
            // overrun of the sentence buffer
            fr.push_back(nrmc_pkg::CH_DOLLAR);
            repeat ($urandom_range(nrmc_pkg::MAX_SENTENCE_LEN - 1,
                                   nrmc_pkg::MAX_SENTENCE_LEN + 6)) begin
                fr.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            if ($urandom_range(0, 3) == 0) begin
                fr.push_back(nrmc_pkg::CH_DOLLAR);
            end
            commit_frame(fr, 1'b0, 1'b0, 1'b0, 1'b0);
        end else if (mode < 91) begin
            // short sentence of arbitrary bytes
            fr.push_back(nrmc_pkg::CH_DOLLAR);
            repeat ($urandom_range(0, 10)) fr.push_back(8'($urandom_range(0, 255)));
            fr.push_back(nrmc_pkg::CH_CR);
            fr.push_back(nrmc_pkg::CH_LF);
            commit_frame(fr, 1'b0, 1'b0, 1'b0, 1'b0);
        end else begin
            // line noise
            repeat ($urandom_range(1, 20)) fr.push_back(8'($urandom_range(0, 255)));
            commit_frame(fr, 1'b0, 1'b0, 1'b0, 1'b0);
            counted = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string fmt_res(nrmc_pkg::result_t r);
        return $sformatf("kind=%0d time=%0d:%0d:%0d date=%0d/%0d/%0d fix=%02h stray=%0b",
                         r.kind, r.hour, r.minute, r.second, r.day, r.month, r.year,
                         r.fix_status, r.stray);
    endfunction

    task automatic check_result(nrmc_pkg::result_t got);
        nrmc_pkg::result_t want;
        string             diff;
        results_seen++;
        kind_hits[int'(got.kind)]++;
        if (got.stray) begin
            stray_hits++;
        end
        if (parse_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("[%0t] unexpected result: %s", $realtime, fmt_res(got));
            end
        end else begin
            want = parse_results.pop_front();
            diff = "";
            if (got.kind       !== want.kind)       diff = {diff, " kind"};
            if (got.hour       !== want.hour)       diff = {diff, " hour"};
            if (got.minute     !== want.minute)     diff = {diff, " minute"};
            if (got.second     !== want.second)     diff = {diff, " second"};
            if (got.day        !== want.day)        diff = {diff, " day"};
            if (got.month      !== want.month)      diff = {diff, " month"};
            if (got.year       !== want.year)       diff = {diff, " year"};
            if (got.fix_status !== want.fix_status) diff = {diff, " fix_status"};
            if (got.stray      !== want.stray)      diff = {diff, " stray_start"};
            if (diff != "") begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("[%0t] result %0d differs in%s", $realtime, results_seen, diff);
                    $display("    expected %s", fmt_res(want));
                    $display("    actual   %s", fmt_res(got));
                end
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin : monitor
        nrmc_pkg::result_t got, r;
        bit                closed;
        s_took <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.kind       = nrmc_pkg::kind_t'(m_result_kind);
                got.hour       = m_hour;
                got.minute     = m_minute;
                got.second     = m_second;
                got.day        = m_day;
                got.month      = m_month;
                got.year       = m_year;
                got.fix_status = m_fix_status;
                got.stray      = m_stray_start;
                check_result(got);
            end
            if (s_valid && s_ready) begin
                bytes_sent++;
                closed = rmc_step(s_rx_byte, r);
                if (s_tag && table_results.size() != 0) begin
                    r = table_results.pop_front();
                end
                if (closed) begin
                    parse_results.push_back(r);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            // holding the current transaction
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid  <= 1'b0;
        end else if (tx_fifo.size() != 0) begin
            s_valid   <= 1'b1;
            s_rx_byte <= tx_fifo[0].b;
            s_tag     <= tx_fifo[0].typed_end;
            tx_fifo.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 48);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            rdy_tick <= rdy_tick + 1;
            if (rdy_left == 0) begin
                rdy_mode <= $urandom_range(0, 3);
                rdy_left <= $urandom_range(16, 96);
            end else begin
                rdy_left <= rdy_left - 1;
            end
            case (rdy_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= ((rdy_tick % 5) > 1);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        logic [7:0] fr[$];
        int         dir_bytes, rnd_frames;
        bit         counted;
        foreach (snt_buf[i]) snt_buf[i] = 8'h00;
        foreach (kind_hits[i]) kind_hits[i] = 0;

        // Directed table
        dir_row("AB,\015\012", 0, 8'h00, "", 1'b0, 1'b0, '0);
        dir_row("$\015\012", 0, 8'h00, "", 1'b0, 1'b1,
                mk_res(nrmc_pkg::KIND_BAD_HEADER, 0, 0, 0, 0, 0, 0, 8'h00, 1'b0));
        dir_row("$GPX\015\012", 0, 8'h00, "", 1'b0, 1'b1,
                mk_res(nrmc_pkg::KIND_BAD_HEADER, 0, 0, 0, 0, 0, 0, 8'h00, 1'b0));
        dir_row("$GP$\015\012", 0, 8'h00, "", 1'b0, 1'b1,
                mk_res(nrmc_pkg::KIND_BAD_HEADER, 0, 0, 0, 0, 0, 0, 8'h00, 1'b1));
        dir_row("$GPRMC,*00\015\012", 0, 8'h00, "", 1'b0, 1'b1,
                mk_res(nrmc_pkg::KIND_BAD_CSUM, 0, 0, 0, 0, 0, 0, 8'h00, 1'b0));
        dir_row("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
                0, 8'h00, "", 1'b1, 1'b1,
                mk_res(nrmc_pkg::KIND_OK, 12, 35, 19, 23, 3, 94, "A", 1'b0));
        dir_row("GPRMC,000000,V,,,,,,,000000,,", 0, 8'h00, "", 1'b1, 1'b0, '0);
        dir_row("GPRMC,999999,A,,,,,,,999999,,", 0, 8'h00, "", 1'b1, 1'b0, '0);
        // missing date, missing status, digits past the end
        dir_row("GPRMC,235959,A,,,,", 0, 8'h00, "", 1'b1, 1'b0, '0);
        dir_row("GPRMC", 0, 8'h00, "", 1'b1, 1'b0, '0);
        dir_row("GPRMC,", 3, 8'hFF, ",A,,,,,,,123456,", 1'b1, 1'b0, '0);
        dir_row("GPRMC,", 3, 8'h00, ",V,,,,,,,654321,", 1'b1, 1'b0, '0);
        // checksum digits outside the hex set
        dir_row("$GPRMC,*=7\015\012", 0, 8'h00, "", 1'b0, 1'b0, '0);
        dir_row("$GPRMC,1*ab\015\012", 0, 8'h00, "", 1'b0, 1'b0, '0);
        // stray start inside an otherwise good sentence
        dir_row("GPRMC,101010,A,$,,,,,,311299,,", 0, 8'h00, "", 1'b1, 1'b0, '0);
        // overruns, the second one dropping a '$'
        dir_row("$", nrmc_pkg::MAX_SENTENCE_LEN, 8'h58, "", 1'b0, 1'b1,
                mk_res(nrmc_pkg::KIND_OVERFLOW, 0, 0, 0, 0, 0, 0, 8'h00, 1'b0));
        dir_row("$", nrmc_pkg::MAX_SENTENCE_LEN - 1, 8'h58, "$", 1'b0, 1'b1,
                mk_res(nrmc_pkg::KIND_OVERFLOW, 0, 0, 0, 0, 0, 0, 8'h00, 1'b1));
        // sentence that fills the buffer exactly
        dir_row("GPRMC,", nrmc_pkg::MAX_SENTENCE_LEN - 12, 8'h5A, "", 1'b1, 1'b0, '0);

        foreach (dir_tbl[i]) begin
            fr.delete();
            push_text(fr, dir_tbl[i].head);
            repeat (dir_tbl[i].pad_n) fr.push_back(dir_tbl[i].pad_ch);
            push_text(fr, dir_tbl[i].tail);
            commit_frame(fr, dir_tbl[i].seal, 1'b0, 1'b0, dir_tbl[i].typed);
            if (dir_tbl[i].typed) begin
                table_results.push_back(dir_tbl[i].want);
            end
        end
        dir_bytes = tx_fifo.size();

        // Random part
        rnd_frames = 0;
        while (tx_fifo.size() - dir_bytes < RAND_BYTES || rnd_frames < RAND_FRAMES) begin
            gen_random_frame(counted);
            if (counted) begin
                rnd_frames++;
            end
        end

        // Reset, then let the pacing processes run
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (tx_fifo.size() != 0 || s_valid);
        while (parse_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d bytes and %0d results, %0d with a stray start",
                 bytes_sent, results_seen, stray_hits);
        $display("Kinds seen: accepted %0d, bad header %0d, bad checksum %0d, overflow %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still outstanding", parse_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
